// ===== sv/sweep_prune_pair_tracker_macros.svh =====
// Assertion macros shared by the sweep-and-prune pair tracker RTL.
`ifndef SWEEP_PRUNE_PAIR_TRACKER_MACROS_SVH
`define SWEEP_PRUNE_PAIR_TRACKER_MACROS_SVH

// Same-cycle implication, reset masked.
`define SPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define SPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spt_pkg.sv =====
// Types, constants and helper functions of the sweep-and-prune pair tracker.
package spt_pkg;

  localparam int MAX_BOXES  = 8;
  localparam int COORD_BITS = 16;
  localparam int NUM_AXES   = 3;
  localparam int MAX_ENDS   = 2 * MAX_BOXES;
  localparam int MAX_OUT    = 28;
  localparam int BOX_W      = $clog2(MAX_BOXES);
  localparam int ENT_W      = BOX_W + 1;
  localparam int POS_W      = $clog2(MAX_ENDS);
  localparam int CNT_W      = $clog2(MAX_ENDS + 1);
  localparam int AX_W       = 2;
  localparam int BND_W      = 2 * NUM_AXES * COORD_BITS;
  localparam int HIT_W      = $clog2(MAX_OUT + 1);
  localparam int PIDX_W     = $clog2(MAX_BOXES * MAX_BOXES);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_NOT_LIVE     = 2'd1,
    ST_ALREADY_LIVE = 2'd2,
    ST_PAIR         = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WR,
    S_RM_RD,
    S_RM_WR,
    S_SRT_KEY,
    S_SRT_KBND,
    S_SRT_SRD,
    S_SRT_SBND,
    S_SRT_CMP,
    S_SRT_KWR,
    S_REP,
    S_FIN
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [2:0]         box_id;
    logic               is_static;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] first_box;
    logic [2:0] second_box;
    logic       pair_valid;
    logic       last;
  } out_item_t;

  // Bounds word layout: slot (axis * 2 + side), side 1 is the max bound.
  function automatic logic [BND_W-1:0] pack_bounds(input in_item_t it);
    logic [BND_W-1:0] b;
    b = '0;
    b[0*COORD_BITS +: COORD_BITS] = coord_t'(it.min_x);
    b[1*COORD_BITS +: COORD_BITS] = coord_t'(it.max_x);
    b[2*COORD_BITS +: COORD_BITS] = coord_t'(it.min_y);
    b[3*COORD_BITS +: COORD_BITS] = coord_t'(it.max_y);
    b[4*COORD_BITS +: COORD_BITS] = coord_t'(it.min_z);
    b[5*COORD_BITS +: COORD_BITS] = coord_t'(it.max_z);
    return b;
  endfunction

  function automatic coord_t coord_of(input logic [BND_W-1:0] b,
                                      input logic [AX_W-1:0] ax, input logic side);
    int base;
    base = (int'(ax) * 2 + int'(side)) * COORD_BITS;
    return coord_t'(b[base +: COORD_BITS]);
  endfunction

  // Inclusive overlap on all axes.
  function automatic logic boxes_overlap(input logic [BND_W-1:0] a,
                                         input logic [BND_W-1:0] b);
    logic ok;
    coord_t amin, amax, bmin, bmax;
    ok = 1'b1;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      amin = coord_t'(a[(2*ax)*COORD_BITS +: COORD_BITS]);
      amax = coord_t'(a[(2*ax+1)*COORD_BITS +: COORD_BITS]);
      bmin = coord_t'(b[(2*ax)*COORD_BITS +: COORD_BITS]);
      bmax = coord_t'(b[(2*ax+1)*COORD_BITS +: COORD_BITS]);
      if (amin > bmax || bmin > amax) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [PIDX_W-1:0] pair_idx(input logic [BOX_W-1:0] a,
                                                 input logic [BOX_W-1:0] b);
    return PIDX_W'(int'(a) * MAX_BOXES + int'(b));
  endfunction

endpackage

// ===== sv/spt_bounds_ram.sv =====
// Box bounds memory: one write port, two enabled registered read ports.
module spt_bounds_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [spt_pkg::BOX_W-1:0]      wr_addr,
  input  logic [spt_pkg::BND_W-1:0]      wr_data,
  input  logic                           rda_en,
  input  logic [spt_pkg::BOX_W-1:0]      rda_addr,
  output logic [spt_pkg::BND_W-1:0]      rda_data,
  input  logic                           rdb_en,
  input  logic [spt_pkg::BOX_W-1:0]      rdb_addr,
  output logic [spt_pkg::BND_W-1:0]      rdb_data
);

  logic [spt_pkg::BND_W-1:0] mem [spt_pkg::MAX_BOXES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      rda_data <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_data <= mem[rdb_addr];
    end
  end

endmodule

// ===== sv/sweep_prune_pair_tracker.sv =====
// Sweep-and-prune pair tracker top level: sequencer, endpoint order memory, pair set.
// Keeps up to MAX_BOXES boxes and three endpoint orders in memories, and a set of candidate
// pairs in flip-flops. One beat is taken at a time; in_stall stays high until the last result
// beat of the current item has been loaded into the output register, which then drains on its
// own while the next beat is accepted. Update and rejected commands go straight to the result
// beat; add makes six endpoint writes through the single write port of the order memory.
// Remove reads each stored endpoint on each axis and writes back the ones it keeps. Query
// insertion-sorts each axis through the order memory, reading the key and each endpoint it
// shifts, then walks the MAX_BOXES x MAX_BOXES pair matrix one entry a cycle and emits up to
// 28 pair beats, the final one carrying last. A query with nothing to report returns one
// beat with status done. Output stalls hold the walk. Reset clears the live, static and pair
// bits and the endpoint count; the memories need no clearing since only live slots and
// stored endpoints are ever read.
`include "sweep_prune_pair_tracker_macros.svh"

module sweep_prune_pair_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spt_pkg::out_item_t out_data
);

  // Control state
  spt_pkg::state_t                     state_r, state_nxt;
  spt_pkg::in_item_t                   item_r, item_nxt;
  spt_pkg::status_t                    stat_r, stat_nxt;
  logic [spt_pkg::AX_W-1:0]            ax_r, ax_nxt;
  logic [spt_pkg::CNT_W-1:0]           j_r, j_nxt;
  logic [spt_pkg::CNT_W-1:0]           i_r, i_nxt;
  logic [spt_pkg::CNT_W-1:0]           kept_r, kept_nxt;
  logic [spt_pkg::CNT_W-1:0]           cnt_ep_r, cnt_ep_nxt;
  logic [2:0]                          sub_r, sub_nxt;
  logic [spt_pkg::ENT_W-1:0]           key_r, key_nxt;
  logic [spt_pkg::BOX_W-1:0]           pi_r, pi_nxt;
  logic [spt_pkg::BOX_W-1:0]           pj_r, pj_nxt;
  logic                                pend_v_r, pend_v_nxt;
  logic [spt_pkg::BOX_W-1:0]           pend_a_r, pend_a_nxt;
  logic [spt_pkg::BOX_W-1:0]           pend_b_r, pend_b_nxt;
  logic [spt_pkg::HIT_W-1:0]           hits_r, hits_nxt;
  logic [spt_pkg::MAX_BOXES-1:0]       live_r, live_nxt;
  logic [spt_pkg::MAX_BOXES-1:0]       static_r, static_nxt;
  logic [spt_pkg::MAX_BOXES*spt_pkg::MAX_BOXES-1:0] pair_r, pair_nxt;
  logic                                out_valid_r, out_valid_nxt;
  spt_pkg::out_item_t                  out_data_r, out_data_nxt;

  // Endpoint order memory
  logic [spt_pkg::ENT_W-1:0] order_mem [spt_pkg::NUM_AXES][spt_pkg::MAX_ENDS];
  logic [spt_pkg::ENT_W-1:0] order_q;
  logic                      ord_re, ord_we;
  logic [spt_pkg::AX_W-1:0]  ord_rax, ord_wax;
  logic [spt_pkg::POS_W-1:0] ord_rpos, ord_wpos;
  logic [spt_pkg::ENT_W-1:0] ord_wdata;

  // Bounds memory ports
  logic                      bnd_we, rda_en, rdb_en;
  logic [spt_pkg::BOX_W-1:0] rda_addr, rdb_addr;
  logic [spt_pkg::BND_W-1:0] bnd_a_q, bnd_b_q;

  // Shared decode
  logic                      accept, out_free;
  logic                      in_range, in_live, ep_full;
  logic [spt_pkg::BOX_W-1:0] in_box, id_r, kb, sb;
  logic                      gt, ovl, hit;
  logic                      rep_end;
  logic                      rep_or_fin, fin_load;
  logic [spt_pkg::CNT_W-1:0] ip1, add_pos;
  spt_pkg::coord_t           kv, sv;

  spt_bounds_ram u_bounds (
    .clk      (clk),
    .wr_en    (bnd_we),
    .wr_addr  (in_box),
    .wr_data  (spt_pkg::pack_bounds(in_data)),
    .rda_en   (rda_en),
    .rda_addr (rda_addr),
    .rda_data (bnd_a_q),
    .rdb_en   (rdb_en),
    .rdb_addr (rdb_addr),
    .rdb_data (bnd_b_q)
  );

  assign in_stall  = (state_r != spt_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_box   = spt_pkg::BOX_W'(in_data.box_id);
  assign id_r     = spt_pkg::BOX_W'(item_r.box_id);
  assign in_range = (int'(in_data.box_id) < spt_pkg::MAX_BOXES);
  assign in_live  = live_r[in_box];
  assign ep_full  = (cnt_ep_r > spt_pkg::CNT_W'(spt_pkg::MAX_ENDS - 2));

  // Sort compare: key bounds sit on port A, the shifted endpoint's on port B.
  assign kb  = key_r[spt_pkg::BOX_W-1:0];
  assign sb  = order_q[spt_pkg::BOX_W-1:0];
  assign kv  = spt_pkg::coord_of(bnd_a_q, ax_r, key_r[spt_pkg::BOX_W]);
  assign sv  = spt_pkg::coord_of(bnd_b_q, ax_r, order_q[spt_pkg::BOX_W]);
  assign gt  = (sv > kv);
  assign ovl = spt_pkg::boxes_overlap(bnd_a_q, bnd_b_q);
  assign ip1 = i_r + spt_pkg::CNT_W'(1);
  assign add_pos = cnt_ep_r + spt_pkg::CNT_W'(sub_r[0]);

  assign hit = (pi_r < pj_r) && pair_r[spt_pkg::pair_idx(pi_r, pj_r)] &&
               live_r[pi_r] && live_r[pj_r] && !(static_r[pi_r] && static_r[pj_r]) &&
               (int'(hits_r) < spt_pkg::MAX_OUT);
  assign rep_end = (pi_r == spt_pkg::BOX_W'(spt_pkg::MAX_BOXES - 1)) &&
                   (pj_r == spt_pkg::BOX_W'(spt_pkg::MAX_BOXES - 1));

  assign rep_or_fin = (state_r == spt_pkg::S_REP) || (state_r == spt_pkg::S_FIN);
  assign fin_load   = (state_r == spt_pkg::S_FIN) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spt_pkg::S_IDLE: begin
        if (accept) begin
          priority if (in_data.action == spt_pkg::ACT_QUERY) state_nxt = spt_pkg::S_SRT_KEY;
          else if (!in_range)                                state_nxt = spt_pkg::S_FIN;
          else if (in_data.action == spt_pkg::ACT_ADD) begin
            state_nxt = (in_live || ep_full) ? spt_pkg::S_FIN : spt_pkg::S_ADD_WR;
          end
          else if (!in_live)                                 state_nxt = spt_pkg::S_FIN;
          else if (in_data.action == spt_pkg::ACT_UPDATE)    state_nxt = spt_pkg::S_FIN;
          else                                               state_nxt = spt_pkg::S_RM_RD;
        end
      end
      spt_pkg::S_ADD_WR: begin
        if (sub_r == 3'd5) state_nxt = spt_pkg::S_FIN;
      end
      spt_pkg::S_RM_RD: begin
        if (i_r == cnt_ep_r) begin
          if (ax_r == spt_pkg::AX_W'(spt_pkg::NUM_AXES - 1)) state_nxt = spt_pkg::S_FIN;
        end else begin
          state_nxt = spt_pkg::S_RM_WR;
        end
      end
      spt_pkg::S_RM_WR:    state_nxt = spt_pkg::S_RM_RD;
      spt_pkg::S_SRT_KEY: begin
        if (j_r >= cnt_ep_r) begin
          if (ax_r == spt_pkg::AX_W'(spt_pkg::NUM_AXES - 1)) state_nxt = spt_pkg::S_REP;
        end else begin
          state_nxt = spt_pkg::S_SRT_KBND;
        end
      end
      spt_pkg::S_SRT_KBND: state_nxt = spt_pkg::S_SRT_SRD;
      spt_pkg::S_SRT_SRD:  state_nxt = spt_pkg::S_SRT_SBND;
      spt_pkg::S_SRT_SBND: state_nxt = spt_pkg::S_SRT_CMP;
      spt_pkg::S_SRT_CMP: begin
        if (!gt)                                    state_nxt = spt_pkg::S_SRT_KEY;
        else if (i_r == '0)                         state_nxt = spt_pkg::S_SRT_KWR;
        else                                        state_nxt = spt_pkg::S_SRT_SRD;
      end
      spt_pkg::S_SRT_KWR:  state_nxt = spt_pkg::S_SRT_KEY;
      spt_pkg::S_REP: begin
        if (!(hit && pend_v_r && !out_free) && rep_end) state_nxt = spt_pkg::S_FIN;
      end
      spt_pkg::S_FIN: begin
        if (out_free) state_nxt = spt_pkg::S_IDLE;
      end
      default: state_nxt = spt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    item_nxt      = item_r;
    stat_nxt      = stat_r;
    ax_nxt        = ax_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    kept_nxt      = kept_r;
    cnt_ep_nxt    = cnt_ep_r;
    sub_nxt       = sub_r;
    key_nxt       = key_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    pend_v_nxt    = pend_v_r;
    pend_a_nxt    = pend_a_r;
    pend_b_nxt    = pend_b_r;
    hits_nxt      = hits_r;
    live_nxt      = live_r;
    static_nxt    = static_r;
    pair_nxt      = pair_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ord_re        = 1'b0;
    ord_rax       = ax_r;
    ord_rpos      = i_r[spt_pkg::POS_W-1:0];
    ord_we        = 1'b0;
    ord_wax       = ax_r;
    ord_wpos      = ip1[spt_pkg::POS_W-1:0];
    ord_wdata     = order_q;
    bnd_we        = 1'b0;
    rda_en        = 1'b0;
    rda_addr      = sb;
    rdb_en        = 1'b0;
    rdb_addr      = sb;

    unique case (state_r)
      spt_pkg::S_IDLE: begin
        if (accept) begin
          item_nxt   = in_data;
          stat_nxt   = spt_pkg::ST_DONE;
          pend_v_nxt = 1'b0;
          priority if (in_data.action == spt_pkg::ACT_QUERY) begin
            ax_nxt   = '0;
            j_nxt    = spt_pkg::CNT_W'(1);
            hits_nxt = '0;
            pi_nxt   = '0;
            pj_nxt   = '0;
          end
          else if (!in_range) stat_nxt = spt_pkg::ST_NOT_LIVE;
          else if (in_data.action == spt_pkg::ACT_ADD) begin
            if (in_live || ep_full) begin
              stat_nxt = spt_pkg::ST_ALREADY_LIVE;
            end else begin
              bnd_we             = 1'b1;
              live_nxt[in_box]   = 1'b1;
              static_nxt[in_box] = in_data.is_static;
              sub_nxt            = '0;
            end
          end
          else if (!in_live) stat_nxt = spt_pkg::ST_NOT_LIVE;
          else if (in_data.action == spt_pkg::ACT_UPDATE) bnd_we = 1'b1;
          else begin
            ax_nxt   = '0;
            i_nxt    = '0;
            kept_nxt = '0;
          end
        end
      end
      spt_pkg::S_ADD_WR: begin
        // Append min then max on each axis.
        ord_we    = 1'b1;
        ord_wax   = spt_pkg::AX_W'(sub_r >> 1);
        ord_wpos  = add_pos[spt_pkg::POS_W-1:0];
        ord_wdata = {sub_r[0], id_r};
        sub_nxt   = sub_r + 3'd1;
        if (sub_r == 3'd5) cnt_ep_nxt = cnt_ep_r + spt_pkg::CNT_W'(2);
      end
      spt_pkg::S_RM_RD: begin
        if (i_r == cnt_ep_r) begin
          if (ax_r == spt_pkg::AX_W'(spt_pkg::NUM_AXES - 1)) begin
            cnt_ep_nxt       = kept_r;
            live_nxt[id_r]   = 1'b0;
            static_nxt[id_r] = 1'b0;
            for (int k = 0; k < spt_pkg::MAX_BOXES; k++) begin
              pair_nxt[spt_pkg::pair_idx(id_r, spt_pkg::BOX_W'(k))] = 1'b0;
              pair_nxt[spt_pkg::pair_idx(spt_pkg::BOX_W'(k), id_r)] = 1'b0;
            end
          end else begin
            ax_nxt   = ax_r + spt_pkg::AX_W'(1);
            i_nxt    = '0;
            kept_nxt = '0;
          end
        end else begin
          ord_re = 1'b1;
        end
      end
      spt_pkg::S_RM_WR: begin
        // Compact: keep every endpoint that is not the removed box's.
        if (sb != id_r) begin
          ord_we   = 1'b1;
          ord_wpos = kept_r[spt_pkg::POS_W-1:0];
          kept_nxt = kept_r + spt_pkg::CNT_W'(1);
        end
        i_nxt = ip1;
      end
      spt_pkg::S_SRT_KEY: begin
        if (j_r >= cnt_ep_r) begin
          if (ax_r != spt_pkg::AX_W'(spt_pkg::NUM_AXES - 1)) begin
            ax_nxt = ax_r + spt_pkg::AX_W'(1);
            j_nxt  = spt_pkg::CNT_W'(1);
          end
        end else begin
          ord_re   = 1'b1;
          ord_rpos = j_r[spt_pkg::POS_W-1:0];
        end
      end
      spt_pkg::S_SRT_KBND: begin
        key_nxt  = order_q;
        rda_en   = 1'b1;
        rda_addr = sb;
        i_nxt    = j_r - spt_pkg::CNT_W'(1);
      end
      spt_pkg::S_SRT_SRD: begin
        ord_re = 1'b1;
      end
      spt_pkg::S_SRT_SBND: begin
        rdb_en   = 1'b1;
        rdb_addr = sb;
      end
      spt_pkg::S_SRT_CMP: begin
        ord_we = 1'b1;
        if (gt) begin
          if (kb != sb) begin
            if (!key_r[spt_pkg::BOX_W] && order_q[spt_pkg::BOX_W] && ovl) begin
              pair_nxt[spt_pkg::pair_idx(kb, sb)] = 1'b1;
              pair_nxt[spt_pkg::pair_idx(sb, kb)] = 1'b1;
            end
            if (key_r[spt_pkg::BOX_W] && !order_q[spt_pkg::BOX_W]) begin
              pair_nxt[spt_pkg::pair_idx(kb, sb)] = 1'b0;
              pair_nxt[spt_pkg::pair_idx(sb, kb)] = 1'b0;
            end
          end
          ord_wdata = order_q;
          if (i_r != '0) i_nxt = i_r - spt_pkg::CNT_W'(1);
        end else begin
          ord_wdata = key_r;
          j_nxt     = j_r + spt_pkg::CNT_W'(1);
        end
      end
      spt_pkg::S_SRT_KWR: begin
        ord_we    = 1'b1;
        ord_wpos  = '0;
        ord_wdata = key_r;
        j_nxt     = j_r + spt_pkg::CNT_W'(1);
      end
      spt_pkg::S_REP: begin
        // Hold one found pair back so the final beat can carry last.
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: spt_pkg::ST_PAIR, first_box: 3'(pend_a_r),
                                second_box: 3'(pend_b_r), pair_valid: 1'b1, last: 1'b0};
            end
            pend_v_nxt = 1'b1;
            pend_a_nxt = pi_r;
            pend_b_nxt = pj_r;
            hits_nxt   = hits_r + spt_pkg::HIT_W'(1);
          end
          if (pj_r == spt_pkg::BOX_W'(spt_pkg::MAX_BOXES - 1)) begin
            pj_nxt = '0;
            if (!rep_end) pi_nxt = pi_r + spt_pkg::BOX_W'(1);
          end else begin
            pj_nxt = pj_r + spt_pkg::BOX_W'(1);
          end
        end
      end
      spt_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_data_nxt = '{status: spt_pkg::ST_PAIR, first_box: 3'(pend_a_r),
                             second_box: 3'(pend_b_r), pair_valid: 1'b1, last: 1'b1};
          end else begin
            out_data_nxt = '{status: stat_r, first_box: 3'd0, second_box: 3'd0,
                             pair_valid: 1'b0, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Order memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_wax][ord_wpos] <= ord_wdata;
    end
    if (ord_re) begin
      order_q <= order_mem[ord_rax][ord_rpos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spt_pkg::S_IDLE;
      cnt_ep_r    <= '0;
      live_r      <= '0;
      static_r    <= '0;
      pair_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_ep_r    <= cnt_ep_nxt;
      live_r      <= live_nxt;
      static_r    <= static_nxt;
      pair_r      <= pair_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    stat_r     <= stat_nxt;
    ax_r       <= ax_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    kept_r     <= kept_nxt;
    sub_r      <= sub_nxt;
    key_r      <= key_nxt;
    pi_r       <= pi_nxt;
    pj_r       <= pj_nxt;
    pend_a_r   <= pend_a_nxt;
    pend_b_r   <= pend_b_nxt;
    out_data_r <= out_data_nxt;
  end

  `SPT_ASSERT_IMP(a_ep_live, !in_stall, int'(cnt_ep_r) == 2 * $countones(live_r), "endpoints off")
  `SPT_ASSERT_IMP(a_pend_in_report, pend_v_r, rep_or_fin, "pending pair outside report")
  `SPT_ASSERT_IMP(a_hits_capped, 1'b1, int'(hits_r) <= spt_pkg::MAX_OUT, "too many pair beats")
  `SPT_ASSERT_NXT(a_fin_drains, fin_load, out_valid_r && out_data_r.last, "final beat not loaded")

endmodule

// ===== bench/sweep_prune_pair_tracker_tb.sv =====
// Self-checking bench for the sweep-and-prune pair tracker: directed table, then random traffic.
module sweep_prune_pair_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX = spt_pkg::MAX_BOXES;
  localparam int NEND = spt_pkg::MAX_ENDS;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  spt_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  spt_pkg::out_item_t out_data;

  sweep_prune_pair_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the tracker state.
  logic signed [15:0] bnd_lo [NBOX][3];
  logic signed [15:0] bnd_hi [NBOX][3];
  logic [NBOX-1:0] live_q;
  logic [NBOX-1:0] static_q;
  logic [3:0] ends_q [3][NEND];
  int end_cnt;
  logic pairs_q [NBOX][NBOX];

  spt_pkg::out_item_t pending_beats[$];
  int errors;
  int cycles;
  bit hold_long;

  function automatic logic signed [15:0] end_pos(int ax, logic [3:0] e);
    return e[3] ? bnd_hi[e[2:0]][ax] : bnd_lo[e[2:0]][ax];
  endfunction

  function automatic bit touch(int a, int b);
    for (int ax = 0; ax < 3; ax++) begin
      if (bnd_lo[a][ax] > bnd_hi[b][ax] || bnd_lo[b][ax] > bnd_hi[a][ax]) return 0;
    end
    return 1;
  endfunction

  // A stored pair is reported when both boxes are live and not both static.
  function automatic bit shown(int a, int b);
    return pairs_q[a][b] && live_q[a] && live_q[b] && !(static_q[a] && static_q[b]);
  endfunction

  function automatic spt_pkg::out_item_t beat(spt_pkg::status_t st, int a, int b, bit pv,
                                              bit lst);
    spt_pkg::out_item_t r;
    r.status = st;
    r.first_box = 3'(a);
    r.second_box = 3'(b);
    r.pair_valid = pv;
    r.last = lst;
    return r;
  endfunction

  task automatic queue_beat(spt_pkg::out_item_t b);
    pending_beats = {pending_beats, b};
  endtask

  // Insertion-sort one axis; mins crossing maxes leftward record touching pairs, maxes crossing mins clear.
  task automatic sweep_axis(int ax);
    logic [3:0] key;
    logic [3:0] s;
    int i;
    for (int j = 1; j < end_cnt; j++) begin
      key = ends_q[ax][j];
      i = j - 1;
      while (i >= 0 && end_pos(ax, ends_q[ax][i]) > end_pos(ax, key)) begin
        s = ends_q[ax][i];
        if (key[2:0] != s[2:0]) begin
          if (!key[3] && s[3] && touch(key[2:0], s[2:0])) begin
            pairs_q[key[2:0]][s[2:0]] = 1;
            pairs_q[s[2:0]][key[2:0]] = 1;
          end
          if (key[3] && !s[3]) begin
            pairs_q[key[2:0]][s[2:0]] = 0;
            pairs_q[s[2:0]][key[2:0]] = 0;
          end
        end
        ends_q[ax][i+1] = s;
        i--;
      end
      ends_q[ax][i+1] = key;
    end
  endtask

  // Apply one command to the shadow state and queue the beats it must produce.
  task automatic track_command(spt_pkg::in_item_t it);
    int id;
    int k;
    int kept;
    int total;
    id = it.box_id;
    case (it.action)
      spt_pkg::ACT_QUERY: begin
        for (int ax = 0; ax < 3; ax++) sweep_axis(ax);
        total = 0;
        for (int i = 0; i < NBOX; i++) begin
          for (int j = i + 1; j < NBOX; j++) begin
            if (shown(i, j)) total++;
          end
        end
        if (total > spt_pkg::MAX_OUT) total = spt_pkg::MAX_OUT;
        k = 0;
        for (int i = 0; i < NBOX; i++) begin
          for (int j = i + 1; j < NBOX; j++) begin
            if (shown(i, j) && k < total) begin
              k++;
              queue_beat(beat(spt_pkg::ST_PAIR, i, j, 1, k == total));
            end
          end
        end
        if (total == 0) queue_beat(beat(spt_pkg::ST_DONE, 0, 0, 0, 1));
      end
      spt_pkg::ACT_ADD: begin
        if (live_q[id] || end_cnt + 2 > NEND) begin
          queue_beat(beat(spt_pkg::ST_ALREADY_LIVE, 0, 0, 0, 1));
        end else begin
          bnd_lo[id][0] = it.min_x; bnd_lo[id][1] = it.min_y; bnd_lo[id][2] = it.min_z;
          bnd_hi[id][0] = it.max_x; bnd_hi[id][1] = it.max_y; bnd_hi[id][2] = it.max_z;
          live_q[id] = 1;
          static_q[id] = it.is_static;
          for (int ax = 0; ax < 3; ax++) begin
            ends_q[ax][end_cnt] = {1'b0, 3'(id)};
            ends_q[ax][end_cnt+1] = {1'b1, 3'(id)};
          end
          end_cnt += 2;
          queue_beat(beat(spt_pkg::ST_DONE, 0, 0, 0, 1));
        end
      end
      default: begin
        if (!live_q[id]) begin
          queue_beat(beat(spt_pkg::ST_NOT_LIVE, 0, 0, 0, 1));
        end else if (it.action == spt_pkg::ACT_UPDATE) begin
          bnd_lo[id][0] = it.min_x; bnd_lo[id][1] = it.min_y; bnd_lo[id][2] = it.min_z;
          bnd_hi[id][0] = it.max_x; bnd_hi[id][1] = it.max_y; bnd_hi[id][2] = it.max_z;
          queue_beat(beat(spt_pkg::ST_DONE, 0, 0, 0, 1));
        end else begin
          for (int ax = 0; ax < 3; ax++) begin
            kept = 0;
            for (int i = 0; i < end_cnt; i++) begin
              if (ends_q[ax][i][2:0] != id) begin
                ends_q[ax][kept] = ends_q[ax][i];
                kept++;
              end
            end
          end
          end_cnt -= 2;
          for (int i = 0; i < NBOX; i++) begin
            pairs_q[id][i] = 0;
            pairs_q[i][id] = 0;
          end
          live_q[id] = 0;
          static_q[id] = 0;
          queue_beat(beat(spt_pkg::ST_DONE, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  function automatic spt_pkg::in_item_t cmd(spt_pkg::action_t a, int id, bit st, int lx,
                                            int ly, int lz, int hx, int hy, int hz);
    spt_pkg::in_item_t it;
    it.action = a;
    it.box_id = 3'(id);
    it.is_static = st;
    it.min_x = 16'(lx); it.min_y = 16'(ly); it.min_z = 16'(lz);
    it.max_x = 16'(hx); it.max_y = 16'(hy); it.max_z = 16'(hz);
    return it;
  endfunction

  // Short gaps mostly, an occasional long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat, hold it steady until taken, then fold it into the shadow state.
  task automatic send_beat(spt_pkg::in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_command(it);
  endtask

  function automatic int rc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 6) return $urandom_range(0, 200) - 100;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Random box, mostly well-formed, sometimes left inverted on one or more axes.
  function automatic spt_pkg::in_item_t rand_box(spt_pkg::action_t a, int id);
    int lo[3];
    int hi[3];
    int t;
    for (int ax = 0; ax < 3; ax++) begin
      lo[ax] = rc();
      hi[ax] = rc();
      if ($urandom_range(0, 9) != 0 && lo[ax] > hi[ax]) begin
        t = lo[ax]; lo[ax] = hi[ax]; hi[ax] = t;
      end
    end
    return cmd(a, id, $urandom_range(0, 1), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Directed table: rows with a typed answer are checked against it as well.
  typedef struct {
    spt_pkg::in_item_t it;
    bit has_ans;
    spt_pkg::out_item_t ans;
  } row_t;

  row_t rows[$];

  task automatic add_row(spt_pkg::in_item_t it, bit has_ans, spt_pkg::status_t st);
    row_t r;
    r.it = it;
    r.has_ans = has_ans;
    r.ans = beat(st, 0, 0, 0, 1);
    rows = {rows, r};
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
    end
  end

  initial begin
    hold_long = 1'b0;
    wait (rst_n === 1'b1);
    repeat (400) @(posedge clk);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    spt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, out_data);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_data.status !== want.status)
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
        if (out_data.first_box !== want.first_box)
          $display("%0t: first_box expected %0d got %0d", $time, want.first_box,
                   out_data.first_box);
        if (out_data.second_box !== want.second_box)
          $display("%0t: second_box expected %0d got %0d", $time, want.second_box,
                   out_data.second_box);
        if (out_data.pair_valid !== want.pair_valid)
          $display("%0t: pair_valid expected %0b got %0b", $time, want.pair_valid,
                   out_data.pair_valid);
        if (out_data.last !== want.last)
          $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
        if (out_data !== want) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sweep_prune_pair_tracker] ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int id;
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    end_cnt = 0;
    live_q = '0;
    static_q = '0;
    for (int i = 0; i < NBOX; i++) for (int j = 0; j < NBOX; j++) pairs_q[i][j] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty query, misses, extremes, overlaps, static pairs, inverted box.
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_UPDATE, 3, 0, 0, 0, 0, 0, 0, 0), 1, spt_pkg::ST_NOT_LIVE);
    add_row(cmd(spt_pkg::ACT_REMOVE, 7, 0, 0, 0, 0, 0, 0, 0), 1, spt_pkg::ST_NOT_LIVE);
    add_row(cmd(spt_pkg::ACT_ADD, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767), 1,
            spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_ADD, 0, 0, 0, 0, 0, 1, 1, 1), 1, spt_pkg::ST_ALREADY_LIVE);
    add_row(cmd(spt_pkg::ACT_ADD, 7, 1, 10, 10, 10, 20, 20, 20), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_ADD, 1, 1, 20, 20, 20, 30, 30, 30), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_ADD, 2, 0, 5, 5, 5, -5, -5, -5), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_UPDATE, 7, 0, -40, -40, -40, -30, -30, -30), 1,
            spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_UPDATE, 1, 0, -35, -35, -35, 100, 100, 100), 1,
            spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_UPDATE, 0, 1, 32767, 32767, 32767, -32768, -32768, -32768), 1,
            spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0), 1, spt_pkg::ST_NOT_LIVE);
    for (int b = 3; b < 7; b++)
      add_row(cmd(spt_pkg::ACT_ADD, b, b[0], -b, -b, -b, 50, 50, 50), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_ADD, 1, 0, 0, 0, 0, 9, 9, 9), 1, spt_pkg::ST_DONE);
    add_row(cmd(spt_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, spt_pkg::ST_DONE);

    foreach (rows[n]) begin
      send_beat(rows[n].it);
      // Typed answer must agree with the prediction just queued.
      if (rows[n].has_ans && pending_beats[$] !== rows[n].ans) begin
        $display("%0t: table row %0d expected %p predicted %p", $time, n, rows[n].ans,
                 pending_beats[$]);
        errors++;
      end
    end

    // Random: mostly move-and-query frames on a busy scene, some noise.
    for (int n = 0; n < 330; n++) begin
      r = $urandom_range(0, 99);
      id = $urandom_range(0, 7);
      if (r < 25) send_beat(rand_box(spt_pkg::ACT_ADD, id));
      else if (r < 55) send_beat(rand_box(spt_pkg::ACT_UPDATE, id));
      else if (r < 67) send_beat(rand_box(spt_pkg::ACT_REMOVE, id));
      else send_beat(rand_box(spt_pkg::ACT_QUERY, id));
    end
    in_valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[sweep_prune_pair_tracker] OK");
    end else begin
      $display("[sweep_prune_pair_tracker] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/spt_pkg.sv
sv/spt_bounds_ram.sv
sv/sweep_prune_pair_tracker.sv
bench/sweep_prune_pair_tracker_tb.sv
